FILE: hw/rtl/sexp_pkg.sv
// Shared types, character codes and helpers of the s-expression tokenizer.
`default_nettype none

package sexp_pkg;

  localparam int unsigned MAX_TOKENS  = 512;
  localparam int unsigned QUEUE_DEPTH = 4;

  // character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BQUOTE = 8'h60;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_TILDE  = 8'h7e;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  localparam logic [1:0] KIND_REGULAR = 2'd0;
  localparam logic [1:0] KIND_LPAREN  = 2'd1;
  localparam logic [1:0] KIND_RPAREN  = 2'd2;

  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_UNCLOSED = 2'd1;
  localparam logic [1:0] FAULT_OVERFLOW = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_STR   = 2'd2,
    MODE_TILDE = 2'd3
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tok_byte;
    logic       first_of_token;
    logic       last_of_token;
    logic [1:0] token_kind;
    logic [1:0] fault;
    logic       end_of_line;
  } out_item_t;

  // results of one input item, one or two of them
  typedef struct packed {
    logic      two;
    out_item_t res0;
    out_item_t res1;
  } res_pair_t;

  function automatic logic is_sep(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_COMMA);
  endfunction

  function automatic logic is_single(input logic [7:0] b);
    return (b == CH_LBRACK) || (b == CH_RBRACK) || (b == CH_LBRACE) ||
           (b == CH_RBRACE) || (b == CH_LPAREN) || (b == CH_RPAREN) ||
           (b == CH_SQUOTE) || (b == CH_BQUOTE) || (b == CH_SEMI);
  endfunction

  function automatic out_item_t mk_res(input logic [7:0] b, input logic first,
                                       input logic last, input logic [1:0] kind);
    out_item_t r;
    r.tok_byte       = b;
    r.first_of_token = first;
    r.last_of_token  = last;
    r.token_kind     = kind;
    r.fault          = FAULT_NONE;
    r.end_of_line    = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/s_expression_tokenizer.sv
// Top level of the streaming s-expression tokenizer.
//
// Takes one byte of a line per cycle and emits token bytes with first/last
// marks, a paren kind, and on the last item of each line the end mark and any
// fault (unclosed string, or more than MaxTokens tokens, after which the rest
// of the line is dropped). The scanner in the front end takes a new byte every
// cycle while the result queue (QueueDepth entries) has room; each byte gives
// zero, one or two results. Results leave at one per cycle while out_ready_i
// is high, so a byte that gives two results occupies the output for two
// handshakes, and the output side sets the sustained rate. An accepted byte's
// results are registered in the result queue before they reach the output.
`default_nettype none

module s_expression_tokenizer #(
  parameter int unsigned MaxTokens  = sexp_pkg::MAX_TOKENS,
  parameter int unsigned QueueDepth = sexp_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire sexp_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output sexp_pkg::out_item_t      out_item_o
);
  import sexp_pkg::*;

  logic      push, pop, full, empty;
  res_pair_t pair, head;

  sexp_front #(
    .MaxTokens(MaxTokens)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_item_i (in_item_i),
    .full_i    (full),
    .push_o    (push),
    .pair_o    (pair)
  );

  sexp_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pair_i (pair),
    .pop_i  (pop),
    .head_o (head),
    .full_o (full),
    .empty_o(empty)
  );

  sexp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // the front end must never write into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !full)
    else $error("push into full result queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !empty)
    else $error("pop from empty result queue");

  // a fault is only reported with the end of a line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && out_item_o.fault != FAULT_NONE) |->
                   out_item_o.end_of_line)
    else $error("fault outside end-of-line item");

  // second result of a pair is only selected while the head holds two
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && u_back.idx_q) |-> head.two)
    else $error("second result selected from single-result entry");

endmodule

`default_nettype wire

FILE: hw/rtl/sexp_front.sv
// Front end: takes input bytes, runs the scanner state and builds each item's results.
`default_nettype none

module sexp_front #(
  parameter int unsigned MaxTokens = 512
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire sexp_pkg::in_item_t   in_item_i,
  input  wire logic                 full_i,
  output logic                      push_o,
  output sexp_pkg::res_pair_t       pair_o
);
  import sexp_pkg::*;

  localparam int unsigned CntW = $clog2(MaxTokens + 1);

  scan_mode_e      mode_q, mode_d, mode_eff;
  logic [7:0]      held_byte_q, held_byte_d;
  logic            held_valid_q, held_valid_d;
  logic            held_first_q, held_first_d;
  logic            bs_q, bs_d;
  logic [CntW-1:0] count_q, count_d;
  logic            drop_q, drop_d;

  out_item_t  res [2];
  logic [1:0] n, n_m1;
  logic       start;
  logic [1:0] fault;
  logic [7:0] b;
  logic       accept;

  assign b          = in_item_i.in_byte;
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    mode_d       = mode_q;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    held_first_d = held_first_q;
    bs_d         = bs_q;
    count_d      = count_q;
    drop_d       = drop_q;
    res[0]       = '0;
    res[1]       = '0;
    n            = 2'd0;
    n_m1         = 2'd0;
    start        = 1'b0;
    fault        = FAULT_NONE;
    mode_eff     = held_valid_q ? mode_q : MODE_IDLE;

    if (!drop_q) begin
      mode_d = mode_eff;
      unique case (mode_eff)
        MODE_IDLE: begin
          start = 1'b1;
        end
        MODE_STR: begin
          if (b == CH_DQUOTE && !bs_q) begin
            res[0]       = mk_res(held_byte_q, held_first_q, 1'b0, KIND_REGULAR);
            res[1]       = mk_res(b, 1'b0, 1'b1, KIND_REGULAR);
            n            = 2'd2;
            held_valid_d = 1'b0;
            mode_d       = MODE_IDLE;
          end else begin
            res[0]       = mk_res(held_byte_q, held_first_q, 1'b0, KIND_REGULAR);
            n            = 2'd1;
            held_byte_d  = b;
            held_first_d = 1'b0;
            bs_d         = (b == CH_BSLASH);
          end
        end
        MODE_RUN, MODE_TILDE: begin
          if (mode_eff == MODE_TILDE && b == CH_AT) begin
            res[0]       = mk_res(held_byte_q, held_first_q, 1'b0, KIND_REGULAR);
            res[1]       = mk_res(b, 1'b0, 1'b1, KIND_REGULAR);
            n            = 2'd2;
            held_valid_d = 1'b0;
            mode_d       = MODE_IDLE;
          end else if (is_sep(b) || is_single(b)) begin
            res[0]       = mk_res(held_byte_q, held_first_q, 1'b1, KIND_REGULAR);
            n            = 2'd1;
            held_valid_d = 1'b0;
            mode_d       = MODE_IDLE;
            start        = 1'b1;
          end else begin
            res[0]       = mk_res(held_byte_q, held_first_q, 1'b0, KIND_REGULAR);
            n            = 2'd1;
            held_byte_d  = b;
            held_first_d = 1'b0;
            mode_d       = MODE_RUN;
          end
        end
        default: begin
          mode_d = MODE_IDLE;
        end
      endcase

      // token start; the token counter is only incremented here
      if (start && !is_sep(b)) begin
        if (count_q >= CntW'(MaxTokens)) begin
          drop_d = 1'b1;
        end else begin
          count_d = count_q + CntW'(1);
          if (is_single(b)) begin
            res[n[0]] = mk_res(b, 1'b1, 1'b1,
                               (b == CH_LPAREN) ? KIND_LPAREN :
                               (b == CH_RPAREN) ? KIND_RPAREN : KIND_REGULAR);
            n      = n + 2'd1;
            mode_d = MODE_IDLE;
          end else begin
            held_byte_d  = b;
            held_valid_d = 1'b1;
            held_first_d = 1'b1;
            if (b == CH_DQUOTE) begin
              bs_d   = 1'b0;
              mode_d = MODE_STR;
            end else if (b == CH_TILDE) begin
              mode_d = MODE_TILDE;
            end else begin
              mode_d = MODE_RUN;
            end
          end
        end
      end
    end

    if (in_item_i.line_end) begin
      if (held_valid_d) begin
        if (mode_d == MODE_STR) begin
          fault = FAULT_UNCLOSED;
        end
        res[n[0]]    = mk_res(held_byte_d, held_first_d, 1'b1, KIND_REGULAR);
        n            = n + 2'd1;
        held_valid_d = 1'b0;
      end
      if (drop_d) begin
        fault = FAULT_OVERFLOW;
      end
      if (n == 2'd0) begin
        // bare marker closes a line whose last item produced nothing
        res[0] = mk_res(8'h00, 1'b0, 1'b0, KIND_REGULAR);
        n      = 2'd1;
      end
      n_m1                   = n - 2'd1;
      res[n_m1[0]].fault       = fault;
      res[n_m1[0]].end_of_line = 1'b1;
      mode_d  = MODE_IDLE;
      bs_d    = 1'b0;
      count_d = '0;
      drop_d  = 1'b0;
    end
  end

  assign push_o      = accept && (n != 2'd0);
  assign pair_o.two  = (n == 2'd2);
  assign pair_o.res0 = res[0];
  assign pair_o.res1 = res[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
      held_first_q <= 1'b0;
      bs_q         <= 1'b0;
      count_q      <= '0;
      drop_q       <= 1'b0;
    end else if (accept) begin
      mode_q       <= mode_d;
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
      held_first_q <= held_first_d;
      bs_q         <= bs_d;
      count_q      <= count_d;
      drop_q       <= drop_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sexp_queue.sv
// Short queue of result pairs between the front end and the output side.
`default_nettype none

module sexp_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire sexp_pkg::res_pair_t  pair_i,
  input  wire logic                 pop_i,
  output sexp_pkg::res_pair_t       head_o,
  output logic                      full_o,
  output logic                      empty_o
);
  import sexp_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_pair_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign head_o  = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= pair_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sexp_back.sv
// Output side: sends the one or two results of the queue head, one item per handshake.
`default_nettype none

module sexp_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire sexp_pkg::res_pair_t  head_i,
  input  wire logic                 empty_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output sexp_pkg::out_item_t       out_item_o
);
  import sexp_pkg::*;

  logic idx_q, idx_d;
  logic fire;

  assign out_valid_o = !empty_i;
  assign out_item_o  = idx_q ? head_i.res1 : head_i.res0;
  assign fire        = out_valid_o && out_ready_i;

  always_comb begin
    idx_d = idx_q;
    pop_o = 1'b0;
    if (fire) begin
      if (head_i.two && !idx_q) begin
        idx_d = 1'b1;
      end else begin
        idx_d = 1'b0;
        pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb_s_expression_tokenizer.sv
// Testbench for the s-expression tokenizer: stream checking against a built-in token predictor.
module tb_s_expression_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  import sexp_pkg::*;

  localparam logic [7:0] OTHER_SINGLES [7] = '{
    CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE, CH_SQUOTE, CH_BQUOTE, CH_SEMI
  };
  localparam int unsigned RANDOM_ITEMS = 80;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // set during a stretch where neither side idles
  logic quiet = 1'b0;
  int   errors = 0;

  // predictor state
  out_item_t   tokens_due[$];
  scan_mode_e  scan_st      = MODE_IDLE;
  logic [7:0]  held_ch      = '0;
  logic        held_live    = 1'b0;
  logic        held_opens   = 1'b0;
  logic        escaped      = 1'b0;
  int unsigned tokens_begun = 0;
  logic        dropping     = 1'b0;
  int unsigned step_results = 0;

  s_expression_tokenizer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #2ms;
    $display("tb_s_expression_tokenizer: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic is_gap(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_COMMA);
  endfunction

  function automatic logic is_one_byte_token(input logic [7:0] b);
    if (b == CH_LPAREN || b == CH_RPAREN) return 1'b1;
    foreach (OTHER_SINGLES[i]) if (b == OTHER_SINGLES[i]) return 1'b1;
    return 1'b0;
  endfunction

  task automatic put_tok(input logic [7:0] b, input logic first, input logic last,
                         input logic [1:0] kind);
    out_item_t r;
    r = '{tok_byte: b, first_of_token: first, last_of_token: last, token_kind: kind,
          fault: FAULT_NONE, end_of_line: 1'b0};
    tokens_due.push_back(r);
    step_results++;
  endtask

  task automatic hold_ch(input logic [7:0] b, input logic first);
    held_ch    = b;
    held_live  = 1'b1;
    held_opens = first;
  endtask

  task automatic open_token(input logic [7:0] b);
    if (is_gap(b)) return;
    if (tokens_begun >= MAX_TOKENS) begin
      dropping = 1'b1;
      return;
    end
    tokens_begun++;
    if (is_one_byte_token(b)) begin
      put_tok(b, 1'b1, 1'b1, (b == CH_LPAREN) ? KIND_LPAREN :
                             (b == CH_RPAREN) ? KIND_RPAREN : KIND_REGULAR);
      scan_st = MODE_IDLE;
    end else if (b == CH_DQUOTE) begin
      hold_ch(b, 1'b1);
      escaped = 1'b0;
      scan_st = MODE_STR;
    end else if (b == CH_TILDE) begin
      hold_ch(b, 1'b1);
      scan_st = MODE_TILDE;
    end else begin
      hold_ch(b, 1'b1);
      scan_st = MODE_RUN;
    end
  endtask

  task automatic extend_run(input logic [7:0] b);
    if (is_gap(b) || is_one_byte_token(b)) begin
      put_tok(held_ch, held_opens, 1'b1, KIND_REGULAR);
      held_live = 1'b0;
      scan_st   = MODE_IDLE;
      open_token(b);
    end else begin
      put_tok(held_ch, held_opens, 1'b0, KIND_REGULAR);
      hold_ch(b, 1'b0);
      scan_st = MODE_RUN;
    end
  endtask

  // two-byte close: held byte plus the closing one
  task automatic close_pair(input logic [7:0] b);
    put_tok(held_ch, held_opens, 1'b0, KIND_REGULAR);
    put_tok(b, 1'b0, 1'b1, KIND_REGULAR);
    held_live = 1'b0;
    scan_st   = MODE_IDLE;
  endtask

  task automatic tokenize(input in_item_t it);
    logic [7:0] b;
    logic [1:0] flt;
    out_item_t  tail;
    b = it.in_byte;
    flt = FAULT_NONE;
    step_results = 0;
    if (!dropping) begin
      if (!held_live && scan_st != MODE_IDLE) scan_st = MODE_IDLE;
      case (scan_st)
        MODE_RUN: extend_run(b);
        MODE_TILDE: begin
          if (b == CH_AT) close_pair(b);
          else extend_run(b);
        end
        MODE_STR: begin
          if (b == CH_DQUOTE && !escaped) begin
            close_pair(b);
          end else begin
            put_tok(held_ch, held_opens, 1'b0, KIND_REGULAR);
            hold_ch(b, 1'b0);
            escaped = (b == CH_BSLASH);
          end
        end
        default: open_token(b);
      endcase
    end
    if (it.line_end) begin
      if (held_live) begin
        if (scan_st == MODE_STR) flt = FAULT_UNCLOSED;
        put_tok(held_ch, held_opens, 1'b1, KIND_REGULAR);
        held_live = 1'b0;
      end
      if (dropping) flt = FAULT_OVERFLOW;
      if (step_results == 0) put_tok(8'h00, 1'b0, 1'b0, KIND_REGULAR);
      tail = tokens_due[tokens_due.size() - 1];
      tail.fault = flt;
      tail.end_of_line = 1'b1;
      tokens_due[tokens_due.size() - 1] = tail;
      scan_st      = MODE_IDLE;
      escaped      = 1'b0;
      tokens_begun = 0;
      dropping     = 1'b0;
    end
  endtask

  // ----------------------------------------------------------------- checking

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= 13);
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (tokens_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, got %p", $time, out_item);
      end else begin
        want = tokens_due.pop_front();
        check_field("tok_byte", want.tok_byte, out_item.tok_byte);
        check_field("first_of_token", want.first_of_token, out_item.first_of_token);
        check_field("last_of_token", want.last_of_token, out_item.last_of_token);
        check_field("token_kind", want.token_kind, out_item.token_kind);
        check_field("fault", want.fault, out_item.fault);
        check_field("end_of_line", want.end_of_line, out_item.end_of_line);
      end
    end
  end

  // ----------------------------------------------------------------- stimulus

  task automatic send_item(input logic [7:0] b, input logic last);
    if (!quiet && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= '{in_byte: b, line_end: last};
    do @(posedge clk_i); while (!in_ready);
    tokenize('{in_byte: b, line_end: last});
  endtask

  task automatic send_line(input logic [7:0] q[$]);
    foreach (q[i]) send_item(q[i], i == q.size() - 1);
  endtask

  task automatic send_text(input string s);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_line(q);
  endtask

  function automatic logic [7:0] rand_letter();
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_gap();
    case ($urandom_range(0, 2))
      0: return CH_SPACE;
      1: return CH_TAB;
      default: return CH_COMMA;
    endcase
  endfunction

  function automatic logic [7:0] rand_paren();
    return $urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN;
  endfunction

  function automatic logic [7:0] rand_single();
    return OTHER_SINGLES[$urandom_range(0, 6)];
  endfunction

  task automatic test_directed();
    logic [7:0] q[$];
    send_text(" ");
    send_text("(~@ ~x\t[`{;'},)");
    // escaped quote, then a double backslash that still escapes: left open
    send_text("\"a\\\"b\\\\\"");
    send_text("\"");
    send_text("\"x\"");
    q = '{8'h00, 8'hff, 8'h80, CH_SPACE, CH_TILDE};
    send_line(q);
  endtask

  // more tokens than allowed in one line, with neither side idling;
  // every byte opens a token, letters never stand next to each other
  task automatic test_token_overflow();
    logic [7:0] q[$];
    quiet = 1'b1;
    for (int i = 0; i < MAX_TOKENS + 4; i++) begin
      if ((i % 2) == 0 && $urandom_range(0, 3) == 0) q.push_back(rand_letter());
      else q.push_back($urandom_range(0, 1) ? rand_paren() : rand_single());
    end
    send_line(q);
    quiet = 1'b0;
  endtask

  task automatic test_random_lines();
    logic [7:0] q[$];
    int unsigned sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      q.delete();
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 10)) q.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 12)) begin
          case ($urandom_range(0, 7))
            0: repeat ($urandom_range(1, 5))
                 q.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(128, 255))
                                                       : rand_letter());
            1, 7: q.push_back(rand_gap());
            2: q.push_back(rand_paren());
            3: begin
              q.push_back(CH_DQUOTE);
              repeat ($urandom_range(0, 5)) begin
                case ($urandom_range(0, 4))
                  0: q.push_back(rand_letter());
                  1: q.push_back(CH_BSLASH);
                  2: begin
                    q.push_back(CH_BSLASH);
                    q.push_back(CH_DQUOTE);
                  end
                  3: q.push_back($urandom_range(0, 1) ? CH_SPACE : rand_paren());
                  default: q.push_back(8'($urandom_range(0, 255)));
                endcase
              end
              if ($urandom_range(0, 4) != 0) q.push_back(CH_DQUOTE);
            end
            4: begin
              q.push_back(CH_TILDE);
              case ($urandom_range(0, 4))
                0, 1, 2: q.push_back(CH_AT);
                3: q.push_back(rand_letter());
                default: ;
              endcase
            end
            5: q.push_back(rand_single());
            default: q.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end
      send_line(q);
      sent += q.size();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_token_overflow();
    test_random_lines();

    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_s_expression_tokenizer: done, clean");
    end else begin
      $display("tb_s_expression_tokenizer: done, errors");
    end
    $finish;
  end

endmodule

FILE: s_expression_tokenizer.f
hw/rtl/sexp_pkg.sv
hw/rtl/sexp_front.sv
hw/rtl/sexp_queue.sv
hw/rtl/sexp_back.sv
hw/rtl/s_expression_tokenizer.sv
sim/tb_s_expression_tokenizer.sv
